### sv/s256_pkg.sv
package s256_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned CountWidth = 61;

	// One entry of the front-to-back queue: a message byte or an end mark.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       final_item;
	} s256_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD
	} s256_state_t;

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

### sv/s256_front.sv
// Input side: classifies items and queues them for the hashing engine.
module s256_front import s256_pkg::*; #(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [7:0] in_byte,
	input  logic      in_no_byte,
	input  logic      in_final,
	output logic      cmd_valid,
	input  logic      cmd_ready,
	output s256_cmd_t cmd
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	s256_cmd_t             fifo_q [DEPTH];
	logic [AW-1:0]         wr_q, rd_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;
	logic                  push, pop, useful;

	// An item with neither byte nor end mark changes nothing and is dropped here.
	assign useful    = !in_no_byte || in_final;
	assign in_ready  = cnt_q != DEPTH[$clog2(DEPTH+1)-1:0];
	assign push      = in_valid && in_ready && useful;
	assign cmd_valid = cnt_q != '0;
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{data_byte: in_byte, has_byte: !in_no_byte,
				final_item: in_final};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
		end
	end

endmodule

### sv/s256_engine.sv
// Back side: block buffer, padding, 64-round compression, digest register.
module s256_engine import s256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  s256_cmd_t   cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [255:0] digest
);

	s256_state_t state_q, state_d;
	logic [31:0] blk_q [16];   // message block, byte 0 in the top of word 0
	logic [31:0] h_q [8];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [5:0]  rnd_q;
	logic [CountWidth-1:0] count_q;
	logic        fin_q;        // end mark seen, closing blocks under way
	logic        need_len_q;   // marker is in the last block, a length-only block is due
	logic        last_q;       // block in flight carries the length
	logic [255:0] dig_q;
	logic        out_valid_q;

	logic [5:0]  rem;
	logic        take, block_full, fold_out;
	logic [31:0] w_new, w_cur, t1, t2;
	logic [63:0] bits;
	logic [31:0] h_sum [8];

	assign rem        = count_q[5:0];
	assign bits       = {count_q, 3'b000};
	assign cmd_ready  = (state_q == ST_IDLE);
	assign take       = cmd_valid && cmd_ready;
	assign block_full = take && cmd.has_byte && (rem == 6'd63);
	assign fold_out   = (state_q == ST_FOLD) && last_q && !out_valid_q;
	assign out_valid  = out_valid_q;
	assign digest     = dig_q;

	assign w_new = w_q[0] + (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
		+ w_q[9] + (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10));
	assign w_cur = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]] : w_new;
	assign t1 = hh_q + (rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25))
		+ ((e_q & f_q) ^ (~e_q & g_q)) + RoundK[rnd_q] + w_cur;
	assign t2 = (rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22))
		+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

	assign h_sum[0] = h_q[0] + a_q;
	assign h_sum[1] = h_q[1] + b_q;
	assign h_sum[2] = h_q[2] + c_q;
	assign h_sum[3] = h_q[3] + d_q;
	assign h_sum[4] = h_q[4] + e_q;
	assign h_sum[5] = h_q[5] + f_q;
	assign h_sum[6] = h_q[6] + g_q;
	assign h_sum[7] = h_q[7] + hh_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (block_full) state_d = ST_LOAD;
					else if (cmd.final_item) state_d = ST_PAD;
				end
			end
			ST_PAD:   state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 6'd63) state_d = ST_FOLD;
			ST_FOLD: begin
				if (last_q) begin
					// The previous digest must leave the output register first.
					if (!out_valid_q) state_d = ST_IDLE;
				end else if (fin_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Block buffer: bytes as they arrive, closing contents in the padding cycle.
	always_ff @(posedge clk) begin
		if (take && cmd.has_byte)
			blk_q[rem[5:2]][{~rem[1:0], 3'b000} +: 8] <= cmd.data_byte;
		if (state_q == ST_PAD) begin
			for (int j = 0; j < 16; j++) begin
				for (int k = 0; k < 4; k++) begin
					if (need_len_q) begin
						blk_q[j][8*(3-k) +: 8] <= (4*j + k >= 56) ?
							bits[8*(63-4*j-k) +: 8] : 8'h00;
					end else if (4*j + k == int'(rem)) begin
						blk_q[j][8*(3-k) +: 8] <= 8'h80;
					end else if (4*j + k > int'(rem)) begin
						blk_q[j][8*(3-k) +: 8] <= (rem < 6'd56 && 4*j + k >= 56) ?
							bits[8*(63-4*j-k) +: 8] : 8'h00;
					end
				end
			end
		end
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < 16; i++)
				w_q[i] <= blk_q[i];
			{a_q, b_q, c_q, d_q} <= {h_q[0], h_q[1], h_q[2], h_q[3]};
			{e_q, f_q, g_q, hh_q} <= {h_q[4], h_q[5], h_q[6], h_q[7]};
		end
		if (state_q == ST_ROUND) begin
			if (rnd_q >= 6'd16) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= w_new;
			end
			hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
		if (fold_out)
			dig_q <= {h_sum[0], h_sum[1], h_sum[2], h_sum[3],
				h_sum[4], h_sum[5], h_sum[6], h_sum[7]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			count_q     <= '0;
			fin_q       <= 1'b0;
			need_len_q  <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD) rnd_q <= '0;
			else if (state_q == ST_ROUND) rnd_q <= rnd_q + 1'b1;
			if (take && cmd.has_byte) count_q <= count_q + 1'b1;
			if (take && cmd.final_item) fin_q <= 1'b1;
			// A tail of 56 bytes or more leaves no room for the length.
			if (state_q == ST_PAD) begin
				if (need_len_q) begin
					need_len_q <= 1'b0;
					last_q     <= 1'b1;
				end else if (rem >= 6'd56) begin
					need_len_q <= 1'b1;
				end else begin
					last_q <= 1'b1;
				end
			end
			if (state_q == ST_FOLD) begin
				if (!last_q) begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_sum[i];
				end else if (!out_valid_q) begin
					for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
					count_q <= '0;
					fin_q   <= 1'b0;
					last_q  <= 1'b0;
				end
			end
			if (fold_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

### sv/sha256_byte_stream_hasher_unit.sv
// Channel | Handshake            | Payload
// s_axis  | s_axis_tvalid/tready | tdata[7:0] data_byte, tuser[0] no_byte, tuser[1] final_item
// m_axis  | m_axis_tvalid/tready | tdata from bit 0: digest_high, upper_mid, lower_mid, low
//
// Items enter a four-entry queue; the engine takes one queued item per cycle while idle,
// and a bare no-byte item without an end mark is dropped at the queue input. The 64th
// byte of a block starts a compression (load, 64 rounds, fold) during which the engine
// takes nothing. A final item adds one padding pass and one closing block, or two
// of each when 56 or more bytes of the last block are used; the digest is valid the cycle
// after the last fold. Reset is asynchronous, active low, and reloads the initial hash
// values. A digest waits in the output register while the sink stalls, and the last fold
// of the next message waits until it is taken; the input side queues until it is full.
module sha256_byte_stream_hasher_unit import s256_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
	input  logic [1:0]   s_axis_tuser,  // [0] no_byte, [1] final_item
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [255:0] m_axis_tdata   // [63:0] digest_high, [127:64] digest_upper_mid,
	                                    // [191:128] digest_lower_mid, [255:192] digest_low
);

	s256_cmd_t    cmd;
	logic         cmd_valid, cmd_ready;
	logic [255:0] dig;

	s256_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_byte(s_axis_tdata), .in_no_byte(s_axis_tuser[0]),
		.in_final(s_axis_tuser[1]),
		.cmd_valid, .cmd_ready, .cmd
	);

	s256_engine u_engine (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .digest(dig)
	);

	// Engine holds hash word 0 at the top; the port puts digest_high lowest.
	assign m_axis_tdata = {dig[63:0], dig[127:64], dig[191:128], dig[255:192]};

endmodule

### sv/s256_checker.sv
module s256_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [255:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("digest dropped under stall");

	a_no_back: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
		else $error("digest repeated");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("digest after reset");

	a_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid |-> !$isunknown(s_axis_tready))
		else $error("input ready unknown");

	a_data_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !$isunknown(m_axis_tdata))
		else $error("digest unknown");

endmodule

bind sha256_byte_stream_hasher_unit s256_checker u_chk (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
